### rtl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
`default_nettype none
package mexp_pkg;
   localparam int FIELD_BITS = 64;
   typedef logic [FIELD_BITS-1:0] field_type;
endpackage
`default_nettype wire

### rtl/mexp_req_if.sv
// request channel: base, exponent and modulus with valid/ready
`default_nettype none
interface mexp_req_if
   import mexp_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type base;
   field_type exponent;
   field_type modulus;

   modport source (output valid, output base, output exponent, output modulus, input ready);
   modport sink (input valid, input base, input exponent, input modulus, output ready);
endinterface
`default_nettype wire

### rtl/mexp_rsp_if.sv
// response channel: power_mod and bad_modulus with valid/ready
`default_nettype none
interface mexp_rsp_if
   import mexp_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type power_mod;
   logic      bad_modulus;

   modport source (output valid, output power_mod, output bad_modulus, input ready);
   modport sink (input valid, input power_mod, input bad_modulus, output ready);
endinterface
`default_nettype wire

### rtl/modular_exponentiation.sv
// sequence: a zero modulus goes straight to the output write; a zero reduced base
// is written after the reduction; otherwise each exponent bit takes a square and,
// if set, a multiply, run on the one-bit-per-cycle shared modular multiply-add step unit
// throughput: one request at a time; the next is taken once the result sits in
// the output register, while that result may still wait for the sink
// reset: synchronous active-high reset idles the sequencer and drops any pending response
`default_nettype none
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  wire           clock,
   input  wire           reset,
   mexp_req_if.sink      req_if,
   mexp_rsp_if.source    rsp_if
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(WORD_BITS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS+1:0] wide_type;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] step_cnt_ff, step_cnt_in;
   logic [CNT_BITS-1:0] exp_cnt_ff, exp_cnt_in;
   word_type            mod_ff, mod_in;
   word_type            base_ff, base_in;
   word_type            exp_ff, exp_in;
   word_type            acc_ff, acc_in;
   word_type            r_ff, r_in;
   word_type            op_a_ff, op_a_in;
   word_type            mplr_ff, mplr_in;
   logic                bad_ff, bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   word_type            rsp_power_ff, rsp_power_in;
   logic                rsp_bad_ff, rsp_bad_in;

   word_type req_base, req_exp, req_mod;
   wide_type sum, sum_m1, sum_m2, mod_x1, mod_x2;
   word_type unit_out;
   logic     last_step, advance;

   assign req_base = req_if.base[WORD_BITS-1:0];
   assign req_exp  = req_if.exponent[WORD_BITS-1:0];
   assign req_mod  = req_if.modulus[WORD_BITS-1:0];

   // shared step unit: (2r + bit*a) mod m with r, a < m, so the sum stays below 3m
   always_comb begin
      mod_x1 = {2'b00, mod_ff};
      mod_x2 = {1'b0, mod_ff, 1'b0};
      sum    = {1'b0, r_ff, 1'b0} + (mplr_ff[WORD_BITS-1] ? {2'b00, op_a_ff} : '0);
      sum_m1 = sum - mod_x1;
      sum_m2 = sum - mod_x2;
      priority if (sum >= mod_x2) begin
         unit_out = sum_m2[WORD_BITS-1:0];
      end else if (sum >= mod_x1) begin
         unit_out = sum_m1[WORD_BITS-1:0];
      end else begin
         unit_out = sum[WORD_BITS-1:0];
      end
   end

   assign last_step = (step_cnt_ff == LAST_CNT);

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      exp_cnt_in   = exp_cnt_ff;
      mod_in       = mod_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      r_in         = r_ff;
      op_a_in      = op_a_ff;
      mplr_in      = mplr_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_power_in = rsp_power_ff;
      rsp_bad_in   = rsp_bad_ff;
      advance      = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_mod == '0) begin
                  acc_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_WRITE;
               end else begin
                  // base mod m as (1 mod m) * base through the same unit
                  mod_in      = req_mod;
                  exp_in      = req_exp;
                  r_in        = '0;
                  op_a_in     = (req_mod == word_type'(1)) ? '0 : word_type'(1);
                  mplr_in     = req_base;
                  step_cnt_in = '0;
                  bad_in      = 1'b0;
                  state_in    = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            r_in        = unit_out;
            mplr_in     = mplr_ff << 1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (last_step) begin
               base_in = unit_out;
               if (unit_out == '0) begin
                  acc_in   = '0;
                  state_in = ST_WRITE;
               end else begin
                  acc_in      = word_type'(1);
                  op_a_in     = word_type'(1);
                  mplr_in     = word_type'(1);
                  r_in        = '0;
                  step_cnt_in = '0;
                  exp_cnt_in  = '0;
                  state_in    = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            r_in        = unit_out;
            mplr_in     = mplr_ff << 1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (last_step) begin
               acc_in = unit_out;
               if (exp_ff[WORD_BITS-1]) begin
                  op_a_in     = unit_out;
                  mplr_in     = base_ff;
                  r_in        = '0;
                  step_cnt_in = '0;
                  state_in    = ST_MULT;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         ST_MULT: begin
            r_in        = unit_out;
            mplr_in     = mplr_ff << 1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (last_step) begin
               acc_in  = unit_out;
               advance = 1'b1;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = acc_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next exponent bit: square again, or finish after the last bit
      if (advance) begin
         exp_in     = exp_ff << 1;
         exp_cnt_in = exp_cnt_ff + 1'b1;
         if (exp_cnt_ff == LAST_CNT) begin
            state_in = ST_WRITE;
         end else begin
            op_a_in     = unit_out;
            mplr_in     = unit_out;
            r_in        = '0;
            step_cnt_in = '0;
            state_in    = ST_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         exp_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         exp_cnt_ff   <= exp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mod_ff       <= mod_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      r_ff         <= r_in;
      op_a_ff      <= op_a_in;
      mplr_ff      <= mplr_in;
      bad_ff       <= bad_in;
      rsp_power_ff <= rsp_power_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.power_mod   = FIELD_BITS'(rsp_power_ff);
   assign rsp_if.bad_modulus = rsp_bad_ff;

`ifndef SYNTHESIS
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted but sequencer still idle");

   a_residue_below_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE || state_ff == ST_SQUARE || state_ff == ST_MULT)
      |-> (r_ff < mod_ff && op_a_ff < mod_ff))
      else $error("step unit operand not reduced");

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.bad_modulus |-> rsp_if.power_mod == '0)
      else $error("zero modulus response carries a nonzero result");

   a_write_posts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE && (!rsp_valid_ff || rsp_if.ready)
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not posted to output register");
`endif

endmodule
`default_nettype wire
